// ===== src/pflm_pkg.sv =====
`default_nettype none
package pflm_pkg;

  // Frequency and level registers share one width.
  localparam int unsigned LEVEL_W = 20;

  // Hertz per microsecond period: frequency = FREQ_SCALE / period_us.
  localparam logic [LEVEL_W-1:0] FREQ_SCALE = LEVEL_W'(1000000);

  // Configuration register map.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_LEVEL = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_LEVEL  = 1'b1;

  localparam logic [LEVEL_W-1:0] EMPTY_LEVEL_RST = LEVEL_W'(10);
  localparam logic [LEVEL_W-1:0] FULL_LEVEL_RST  = LEVEL_W'(20);

endpackage
`default_nettype wire

// ===== src/pflm_in_if.sv =====
`default_nettype none
interface pflm_in_if #(
  parameter int unsigned TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 pin_level;
  logic [TIME_BITS-1:0] now_us;

  modport source (output valid, output pin_level, output now_us, input ready);
  modport sink   (input valid, input pin_level, input now_us, output ready);
endinterface
`default_nettype wire

// ===== src/pflm_out_if.sv =====
`default_nettype none
interface pflm_out_if #(
  parameter int unsigned FRACTION_BITS = 16
);
  logic                            valid;
  logic                            ready;
  logic [pflm_pkg::LEVEL_W-1:0]    frequency_hz;
  logic [FRACTION_BITS:0]          fill_fraction;

  modport source (output valid, output frequency_hz, output fill_fraction, input ready);
  modport sink   (input valid, input frequency_hz, input fill_fraction, output ready);
endinterface
`default_nettype wire

// ===== src/pulse_frequency_level_meter.sv =====
// Pulse frequency level meter.
// Input channel (in_s): one request per pin sample, pin_level plus a
//   free-running microsecond timestamp now_us (wraps modulo 2^TIME_BITS).
// Output channel (out_s): exactly one result per input request, carrying the
//   current frequency_hz and the fill_fraction (2^FRACTION_BITS = full).
// Config port: cfg_we_i / cfg_idx_i / cfg_data_i write empty_level (index 0)
//   or full_level (index 1); write only while the block is idle. New levels
//   apply at the next frequency change.
// Timing: one request is in flight at a time; in_s.ready is low while it is
//   worked on. A single restoring divider (one quotient bit per cycle) does
//   both the period-to-frequency division (20 steps) and the fill division
//   (FRACTION_BITS steps). A sample goes from ST_IDLE through ST_CHECK to
//   ST_FIN; a rising edge with a nonzero period runs ST_FDIV first, and a
//   fresh frequency adds ST_PREP and, if needed, ST_XDIV before ST_FIN.
//   in_s.ready comes back high in the same cycle as out_s.valid.
// Stall: the result sits in an output register; the next request may be
//   accepted while it waits, and the block holds in its final state until
//   the output register frees up.
// Reset (rst_ni low, async): frequency and fraction 0, last level high
//   (pull-up idle), edge time 0, levels back to 10 Hz / 20 Hz.
`default_nettype none
module pulse_frequency_level_meter #(
  parameter int unsigned TIMEOUT_US    = 1000000,
  parameter int unsigned FRACTION_BITS = 16,
  parameter int unsigned TIME_BITS     = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  pflm_in_if.sink                            in_s,
  pflm_out_if.source                         out_s,
  input  wire                                cfg_we_i,
  input  wire [pflm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire [pflm_pkg::LEVEL_W-1:0]        cfg_data_i
);

  localparam int unsigned LW  = pflm_pkg::LEVEL_W;
  // Divider width: holds any divisor (period or level span).
  localparam int unsigned DW  = (TIME_BITS > LW) ? TIME_BITS : LW;
  // Quotient shift register width.
  localparam int unsigned QW  = (FRACTION_BITS > LW) ? FRACTION_BITS : LW;
  localparam int unsigned CW  = $clog2(QW);
  // Timeout compare width: room for TIMEOUT_US (up to 1e8) and the period.
  localparam int unsigned EW  = (TIME_BITS > 27) ? TIME_BITS : 27;
  localparam logic [FRACTION_BITS:0] FRAC_ONE = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

  // Sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;  // wait for a sample
  localparam logic [2:0] ST_FDIV  = 3'd1;  // FREQ_SCALE / period
  localparam logic [2:0] ST_CHECK = 3'd2;  // frequency changed? form level spans
  localparam logic [2:0] ST_PREP  = 3'd3;  // special cases of the fill ratio
  localparam logic [2:0] ST_XDIV  = 3'd4;  // (n << FRACTION_BITS) / d
  localparam logic [2:0] ST_FIN   = 3'd5;  // hand result to output register

  logic [2:0]               state_q, state_d;
  logic                     last_level_q;
  logic [TIME_BITS-1:0]     edge_time_q;
  logic [LW-1:0]            cur_freq_q;
  logic [FRACTION_BITS:0]   cur_frac_q;
  logic [LW-1:0]            empty_q, full_q;
  logic                     out_valid_q;
  logic [LW-1:0]            out_freq_q;
  logic [FRACTION_BITS:0]   out_frac_q;

  // Working registers (no reset needed)
  logic [LW-1:0]            cand_q;
  logic [DW-1:0]            rem_q;
  logic [DW-1:0]            dvs_q;
  logic [QW-2:0]            quo_q;
  logic [CW-1:0]            cnt_q;
  logic                     neg_n_q, neg_d_q;

  // Sample decode
  logic [TIME_BITS-1:0]     elapsed;
  logic                     in_fire;
  logic                     timed_out;

  assign in_fire   = in_s.valid && in_s.ready;
  assign elapsed   = in_s.now_us - edge_time_q;
  assign timed_out = EW'(elapsed) > EW'(TIMEOUT_US);
  assign in_s.ready = (state_q == ST_IDLE);

  // Shared divider step: one restoring step per cycle.
  logic                     feed;
  logic [DW:0]              trial;
  logic                     ge;
  logic [DW-1:0]            rem_step;
  logic [QW-1:0]            quo_shift;

  always_comb begin
    feed      = (state_q == ST_FDIV) ? pflm_pkg::FREQ_SCALE[cnt_q] : 1'b0;
    trial     = {rem_q, feed};
    ge        = (trial >= {1'b0, dvs_q});
    rem_step  = ge ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
    quo_shift = {quo_q, ge};
  end

  // Level spans for the fill ratio
  logic                     cand_ge_empty, full_ge_empty;
  logic [LW-1:0]            n_mag, d_mag;

  always_comb begin
    cand_ge_empty = (cand_q >= empty_q);
    full_ge_empty = (full_q >= empty_q);
    n_mag = cand_ge_empty ? (cand_q - empty_q) : (empty_q - cand_q);
    d_mag = full_ge_empty ? (full_q - empty_q) : (empty_q - full_q);
  end

  logic out_free;
  assign out_free = !out_valid_q || out_s.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if ((in_s.pin_level != last_level_q) && in_s.pin_level &&
              (elapsed != '0)) begin
            state_d = ST_FDIV;
          end else begin
            state_d = ST_CHECK;
          end
        end
      end
      ST_FDIV: begin
        if (cnt_q == '0) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        state_d = (cand_q == cur_freq_q) ? ST_FIN : ST_PREP;
      end
      ST_PREP: begin
        if ((dvs_q == '0) || (rem_q == '0) || (neg_n_q != neg_d_q) ||
            (rem_q >= dvs_q)) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_XDIV;
        end
      end
      ST_XDIV: begin
        if (cnt_q == '0) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      last_level_q <= 1'b1;
      edge_time_q  <= '0;
      cur_freq_q   <= '0;
      cur_frac_q   <= '0;
      empty_q      <= pflm_pkg::EMPTY_LEVEL_RST;
      full_q       <= pflm_pkg::FULL_LEVEL_RST;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        case (cfg_idx_i)
          pflm_pkg::REG_EMPTY_LEVEL: empty_q <= cfg_data_i;
          pflm_pkg::REG_FULL_LEVEL:  full_q  <= cfg_data_i;
          default: ;
        endcase
      end

      if (in_fire && (in_s.pin_level != last_level_q)) begin
        last_level_q <= in_s.pin_level;
        if (in_s.pin_level) edge_time_q <= in_s.now_us;
      end

      if ((state_q == ST_CHECK) && (cand_q != cur_freq_q)) begin
        cur_freq_q <= cand_q;
      end

      if (state_q == ST_PREP) begin
        if ((dvs_q == '0) || (rem_q == '0) || (neg_n_q != neg_d_q)) begin
          cur_frac_q <= '0;
        end else if (rem_q >= dvs_q) begin
          cur_frac_q <= FRAC_ONE;   // ratio at or above one
        end
      end
      if ((state_q == ST_XDIV) && (cnt_q == '0)) begin
        cur_frac_q <= {1'b0, quo_shift[FRACTION_BITS-1:0]};
      end

      if ((state_q == ST_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_s.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          rem_q <= '0;
          dvs_q <= DW'(elapsed);
          quo_q <= '0;
          cnt_q <= CW'(LW - 1);
          if (in_s.pin_level != last_level_q) begin
            // rising edge with zero period saturates; falling edge keeps
            cand_q <= (in_s.pin_level && (elapsed == '0)) ? pflm_pkg::FREQ_SCALE
                                                          : cur_freq_q;
          end else if ((cur_freq_q != '0) && timed_out) begin
            cand_q <= '0;
          end else begin
            cand_q <= cur_freq_q;
          end
        end
      end
      ST_FDIV: begin
        rem_q <= rem_step;
        quo_q <= quo_shift[QW-2:0];
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) cand_q <= quo_shift[LW-1:0];
      end
      ST_CHECK: begin
        rem_q   <= DW'(n_mag);
        dvs_q   <= DW'(d_mag);
        neg_n_q <= !cand_ge_empty;
        neg_d_q <= !full_ge_empty;
        quo_q   <= '0;
        cnt_q   <= CW'(FRACTION_BITS - 1);
      end
      ST_XDIV: begin
        rem_q <= rem_step;
        quo_q <= quo_shift[QW-2:0];
        cnt_q <= cnt_q - 1'b1;
      end
      ST_FIN: begin
        if (out_free) begin
          out_freq_q <= cur_freq_q;
          out_frac_q <= cur_frac_q;
        end
      end
      default: ;
    endcase
  end

  assign out_s.valid         = out_valid_q;
  assign out_s.frequency_hz  = out_freq_q;
  assign out_s.fill_fraction = out_frac_q;

endmodule
`default_nettype wire

// ===== src/pflm_checker.sv =====
`default_nettype none
module pflm_checker #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input wire                             clk_i,
  input wire                             rst_ni,
  input wire                             in_valid_i,
  input wire                             in_ready_i,
  input wire                             out_valid_i,
  input wire                             out_ready_i,
  input wire [pflm_pkg::LEVEL_W-1:0]     frequency_hz_i,
  input wire [FRACTION_BITS:0]           fill_fraction_i
);

  localparam logic [FRACTION_BITS:0] FRAC_ONE = (FRACTION_BITS+1)'(1) << FRACTION_BITS;

  // One request at a time: busy right after an accept.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted while a request is in flight");

  a_freq_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (frequency_hz_i <= pflm_pkg::FREQ_SCALE))
    else $error("frequency above scale");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (fill_fraction_i <= FRAC_ONE))
    else $error("fill fraction above full");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(frequency_hz_i) &&
      $stable(fill_fraction_i))
    else $error("stalled result dropped or changed");

endmodule

bind pulse_frequency_level_meter pflm_checker #(
  .FRACTION_BITS(FRACTION_BITS)
) u_pflm_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_s.valid),
  .in_ready_i      (in_s.ready),
  .out_valid_i     (out_s.valid),
  .out_ready_i     (out_s.ready),
  .frequency_hz_i  (out_s.frequency_hz),
  .fill_fraction_i (out_s.fill_fraction)
);
`default_nettype wire

// ===== tb/sv/pulse_frequency_level_meter_tb.sv =====
`timescale 1ns / 100ps

module pulse_frequency_level_meter_tb;

  // Block parameters, kept at the defaults of the meter.
  localparam int unsigned TIMEOUT_US    = 1000000;
  localparam int unsigned FRACTION_BITS = 16;
  localparam int unsigned TIME_BITS     = 32;
  localparam int unsigned LEVEL_W       = pflm_pkg::LEVEL_W;
  localparam logic [FRACTION_BITS:0] FRAC_FULL = (FRACTION_BITS + 1)'(1) << FRACTION_BITS;

  // Items per random phase (8 phases, about 950 samples in all).
  localparam int unsigned PHASE_COUNT  = 8;
  localparam int unsigned PHASE_ITEMS  = 119;
  // Cycles without any request moving before the run is declared hung.
  localparam int unsigned HANG_LIMIT   = 4000;
  // Worst-case latency of one sample, with margin, for the drain at the end.
  localparam int unsigned DRAIN_CYCLES = 48;

  typedef struct packed {
    logic [LEVEL_W-1:0]     freq;
    logic [FRACTION_BITS:0] frac;
  } meter_reading_t;

  // One directed sample. If has_value is set, the reading is typed in here;
  // otherwise the predictor supplies it.
  typedef struct packed {
    logic                   pin;
    logic [TIME_BITS-1:0]   now_us;
    logic                   has_value;
    logic [LEVEL_W-1:0]     freq;
    logic [FRACTION_BITS:0] frac;
  } sample_row_t;

  // Levels stay at reset (10 Hz empty, 20 Hz full) for this whole table.
  localparam int unsigned DIRECTED_ROWS = 22;
  localparam sample_row_t DIRECTED [DIRECTED_ROWS] = '{
    // after reset: level high as at idle, no edge, nothing measured
    '{1'b1, 32'd0,            1'b1, 20'd0,       17'd0},
    // falling edge only moves the stored level
    '{1'b0, 32'd3,            1'b1, 20'd0,       17'd0},
    // rising edge, 3 us period
    '{1'b1, 32'd3,            1'b0, 20'd0,       17'd0},
    // second rise at the same timestamp: zero period saturates
    '{1'b0, 32'd3,            1'b0, 20'd0,       17'd0},
    '{1'b1, 32'd3,            1'b1, 20'd1000000, 17'h10000},
    // exactly the timeout: still held
    '{1'b1, 32'd1000003,      1'b1, 20'd1000000, 17'h10000},
    // one past the timeout: drops to zero, below empty clamps to 0
    '{1'b1, 32'd1000004,      1'b1, 20'd0,       17'd0},
    // 66666 us period -> 15 Hz, half full
    '{1'b0, 32'd33336,        1'b0, 20'd0,       17'd0},
    '{1'b1, 32'd66669,        1'b0, 20'd0,       17'd0},
    // falling edge long after the rise: no timeout check on it
    '{1'b0, 32'd4000000,      1'b0, 20'd0,       17'd0},
    // same level again: now the timeout hits
    '{1'b0, 32'd4000001,      1'b0, 20'd0,       17'd0},
    // rise after a very long period: 0 Hz
    '{1'b1, 32'd4100001,      1'b0, 20'd0,       17'd0},
    // 5 Hz, below empty: negative ratio clamps to 0
    '{1'b0, 32'd4200001,      1'b0, 20'd0,       17'd0},
    '{1'b1, 32'd4300001,      1'b0, 20'd0,       17'd0},
    // 10 Hz, exactly empty
    '{1'b0, 32'd4350001,      1'b0, 20'd0,       17'd0},
    '{1'b1, 32'd4400001,      1'b0, 20'd0,       17'd0},
    // 20 Hz, exactly full
    '{1'b0, 32'd4420001,      1'b0, 20'd0,       17'd0},
    '{1'b1, 32'd4450001,      1'b0, 20'd0,       17'd0},
    // rise just below the wrap point
    '{1'b0, 32'hFFFF_FFF0,    1'b0, 20'd0,       17'd0},
    '{1'b1, 32'hFFFF_FFF0,    1'b0, 20'd0,       17'd0},
    // rise after the timestamp wrapped: 20 us period
    '{1'b0, 32'hFFFF_FFFF,    1'b0, 20'd0,       17'd0},
    '{1'b1, 32'h0000_0004,    1'b0, 20'd0,       17'd0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                           cfg_we_i;
  logic [pflm_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [LEVEL_W-1:0]             cfg_data_i;

  pflm_in_if  #(.TIME_BITS(TIME_BITS))         in_if ();
  pflm_out_if #(.FRACTION_BITS(FRACTION_BITS)) out_if ();

  pulse_frequency_level_meter #(
    .TIMEOUT_US   (TIMEOUT_US),
    .FRACTION_BITS(FRACTION_BITS),
    .TIME_BITS    (TIME_BITS)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_s      (in_if.sink),
    .out_s     (out_if.source),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Meter predictor: own copy of the levels and the measurement state.
  // ---------------------------------------------------------------------------
  logic [LEVEL_W-1:0]     lvl_empty;
  logic [LEVEL_W-1:0]     lvl_full;
  logic                   pin_seen;
  logic [TIME_BITS-1:0]   rise_at;
  logic [LEVEL_W-1:0]     freq_now;
  logic [FRACTION_BITS:0] frac_now;

  meter_reading_t reading_q [$];
  int unsigned    fail_count;

  // Signed ratio (f - empty) / (full - empty) as Q16, clamped to [0, 1].
  function automatic logic [FRACTION_BITS:0] fill_for(input logic [LEVEL_W-1:0] f);
    longint num;
    longint den;
    longint quo;
    num = longint'(f) - longint'(lvl_empty);
    den = longint'(lvl_full) - longint'(lvl_empty);
    if (den == 0 || num == 0) return '0;
    if ((num < 0) != (den < 0)) return '0;
    if (num < 0) num = -num;
    if (den < 0) den = -den;
    quo = (num <<< FRACTION_BITS) / den;
    if (quo > longint'(FRAC_FULL)) return FRAC_FULL;
    return quo[FRACTION_BITS:0];
  endfunction

  // Advance the meter by one pin sample and return the reading it reports.
  function automatic meter_reading_t meter_update(input logic pin,
                                                  input logic [TIME_BITS-1:0] now);
    logic [TIME_BITS-1:0] elapsed;
    logic [LEVEL_W-1:0]   freq_next;
    meter_reading_t       rd;
    elapsed   = now - rise_at;
    freq_next = freq_now;
    if (pin != pin_seen) begin
      pin_seen = pin;
      if (pin) begin
        if (elapsed == '0) freq_next = pflm_pkg::FREQ_SCALE;
        else freq_next = LEVEL_W'(64'd1000000 / 64'(elapsed));
        rise_at = now;
      end
    end else if (freq_next != '0 && elapsed > TIMEOUT_US) begin
      freq_next = '0;
    end
    if (freq_next != freq_now) begin
      freq_now = freq_next;
      frac_now = fill_for(freq_next);
    end
    rd.freq = freq_now;
    rd.frac = frac_now;
    return rd;
  endfunction

  // ---------------------------------------------------------------------------
  // Sample source. valid is only lowered when a gap is drawn, so a back-to-back
  // request never sees two assignments to valid in one time step.
  // ---------------------------------------------------------------------------
  logic tx_calm;

  task automatic send_sample(input logic pin, input logic [TIME_BITS-1:0] now,
                             input logic has_value, input meter_reading_t typed);
    int unsigned    gap;
    meter_reading_t want;
    if ($urandom_range(0, 39) == 0) tx_calm = ~tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.pin_level <= pin;
    in_if.now_us    <= now;
    do @(posedge clk_i); while (!in_if.ready);
    // Request accepted at this edge.
    want = meter_update(pin, now);
    if (has_value) want = typed;
    reading_q.push_back(want);
  endtask

  // Hold the source off until every reading is back, then let the block settle.
  task automatic drain_readings();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (reading_q.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  // Write both level registers on two consecutive edges; block must be idle.
  task automatic set_levels(input logic [LEVEL_W-1:0] e, input logic [LEVEL_W-1:0] f);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= pflm_pkg::REG_EMPTY_LEVEL;
    cfg_data_i <= e;
    @(posedge clk_i);
    lvl_empty  = e;
    cfg_idx_i  <= pflm_pkg::REG_FULL_LEVEL;
    cfg_data_i <= f;
    @(posedge clk_i);
    lvl_full   = f;
    cfg_we_i   <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall per reading, checks, and the hang watchdog.
  // ---------------------------------------------------------------------------
  logic        rx_calm;
  int unsigned rx_hold;
  int unsigned quiet_cycles;

  always @(posedge clk_i) begin
    meter_reading_t want;
    int unsigned    w;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      rx_hold      = 0;
      quiet_cycles = 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= HANG_LIMIT) begin
        $display("pulse_frequency_level_meter_tb NOT OK");
        $finish;
      end

      if (out_if.valid && out_if.ready) begin
        if (reading_q.size() == 0) begin
          $error("reading with no request outstanding: frequency_hz %0d fill_fraction %0d",
                 out_if.frequency_hz, out_if.fill_fraction);
          fail_count++;
        end else begin
          want = reading_q.pop_front();
          if (out_if.frequency_hz !== want.freq) begin
            $error("frequency_hz mismatch: expected %0d, got %0d",
                   want.freq, out_if.frequency_hz);
            fail_count++;
          end
          if (out_if.fill_fraction !== want.frac) begin
            $error("fill_fraction mismatch: expected %0d, got %0d",
                   want.frac, out_if.fill_fraction);
            fail_count++;
          end
        end
        if ($urandom_range(0, 39) == 0) rx_calm = ~rx_calm;
        w = rx_calm ? 0 : $urandom_range(0, 7);
        if (w != 0) begin
          out_if.ready <= 1'b0;
          rx_hold      = w;
        end
      end else if (!out_if.ready) begin
        if (rx_hold <= 1) out_if.ready <= 1'b1;
        if (rx_hold != 0) rx_hold--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed table, then random phases under different level maps.
  // ---------------------------------------------------------------------------
  initial begin
    logic [TIME_BITS-1:0] t_cur;
    logic                 p_cur;
    logic [TIME_BITS-1:0] rest_us;
    logic [TIME_BITS-1:0] per_us;
    logic [LEVEL_W-1:0]   e_set;
    logic [LEVEL_W-1:0]   f_set;
    int unsigned          f_lo;
    int unsigned          f_hi;
    int unsigned          kind;
    meter_reading_t       typed;

    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.pin_level <= 1'b1;
    in_if.now_us    <= '0;
    cfg_we_i        <= 1'b0;
    cfg_idx_i       <= pflm_pkg::REG_EMPTY_LEVEL;
    cfg_data_i      <= '0;
    fail_count = 0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    lvl_empty  = pflm_pkg::EMPTY_LEVEL_RST;
    lvl_full   = pflm_pkg::FULL_LEVEL_RST;
    pin_seen   = 1'b1;
    rise_at    = '0;
    freq_now   = '0;
    frac_now   = '0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      typed.freq = DIRECTED[i].freq;
      typed.frac = DIRECTED[i].frac;
      send_sample(DIRECTED[i].pin, DIRECTED[i].now_us, DIRECTED[i].has_value, typed);
    end

    t_cur   = 32'h0000_0004;
    p_cur   = 1'b1;
    rest_us = '0;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      // Full drain before every write: also the pause until all readings are back.
      drain_readings();
      case (ph)
        0: begin e_set = '0;            f_set = LEVEL_W'(1000000); end
        1: begin e_set = LEVEL_W'(1000000); f_set = '0;           end
        2: begin e_set = LEVEL_W'(500); f_set = LEVEL_W'(500);    end  // equal levels
        3: begin e_set = '1;            f_set = '0;               end  // above 1 MHz
        4: begin e_set = '0;            f_set = '1;               end
        default: begin
          e_set = LEVEL_W'($urandom_range(0, 3000));
          f_set = LEVEL_W'($urandom_range(0, 3000));
        end
      endcase
      set_levels(e_set, f_set);

      // Pulse rates aimed between the two levels, kept in 1 Hz .. 1 MHz.
      f_lo = (e_set < f_set) ? 32'(e_set) : 32'(f_set);
      f_hi = (e_set < f_set) ? 32'(f_set) : 32'(e_set);
      if (f_hi > 1000000) f_hi = 1000000;
      if (f_lo > f_hi) f_lo = f_hi;
      if (f_lo == 0) f_lo = 1;
      if (f_hi == 0) f_hi = 1;

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 90) begin
          // Well-formed pulse train: fall halfway through the period, then rise.
          if (p_cur) begin
            if (kind < 65)      per_us = 32'(1000000 / $urandom_range(f_lo, f_hi));
            else if (kind < 80) per_us = 32'($urandom_range(0, 12));
            else                per_us = 32'($urandom_range(900000, 1100000));
            t_cur   = t_cur + (per_us >> 1);
            rest_us = per_us - (per_us >> 1);
            p_cur   = 1'b0;
          end else begin
            t_cur = t_cur + rest_us;
            p_cur = 1'b1;
          end
        end else if (kind < 97) begin
          // Level held: quiet stretches, some past the timeout.
          t_cur = t_cur + 32'($urandom_range(0, 1200000));
        end else begin
          // Broken sequence: jump anywhere in the timestamp range.
          t_cur = $urandom;
          p_cur = 1'($urandom);
        end
        send_sample(p_cur, t_cur, 1'b0, '0);
      end
    end

    drain_readings();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (reading_q.size() != 0) begin
      $error("%0d readings never arrived", reading_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("pulse_frequency_level_meter_tb OK");
    end else begin
      $display("pulse_frequency_level_meter_tb NOT OK");
    end
    $finish;
  end

endmodule
